// ----- hw/rtl/b2d_pkg.sv -----
// Shared constants and types for the binary to decimal ASCII converter.
// Used by the shift-add-3 unit, the digit emitter and the top level.
// No dependencies.
package b2d_pkg;

    localparam int INPUT_BITS   = 32;
    localparam int BCD_DIGITS   = 10;
    localparam int BCD_BITS     = 4 * BCD_DIGITS;
    localparam int CNT_BITS     = $clog2(INPUT_BITS + 1);
    localparam int DIG_IDX_BITS = $clog2(BCD_DIGITS);

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [BCD_BITS-1:0] t_bcd;

    // Status from the shift-add-3 unit toward the emitter.
    typedef struct packed {
        logic done;
        t_bcd bcd;
    } t_conv_result;

endpackage

// ----- hw/rtl/b2d_dabble.sv -----
// Iterative shift-add-3 (double dabble) unit: one input bit per cycle.
// Depends on b2d_pkg.
module b2d_dabble import b2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [INPUT_BITS-1:0] i_value,
    output t_conv_result          o_result
);

    logic [INPUT_BITS-1:0] r_bin;
    t_bcd                  r_bcd;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;
    t_bcd                  n_adj;

    // Digits of five or more get three added before the doubling shift.
    // Carries out of the top digit drop, which keeps the value modulo 10^10.
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(INPUT_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[INPUT_BITS-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_BITS-2:0], r_bin[INPUT_BITS-1]};
        end
    end

    assign o_result.done = r_done;
    assign o_result.bcd  = r_bcd;

endmodule

// ----- hw/rtl/b2d_emit.sv -----
// Digit emitter: strips leading zeros and sends one ASCII digit per beat,
// most significant first, from a registered output stage. Depends on b2d_pkg.
module b2d_emit import b2d_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_conv_result i_result,
    input  logic         i_ready,
    output logic         o_valid,
    output logic [5:0]   o_digit_char,
    output logic         o_last_digit,
    output logic         o_done
);

    t_bcd                    r_bcd;
    logic [DIG_IDX_BITS-1:0] r_idx;
    logic                    r_valid;
    logic [5:0]              r_char;
    logic                    r_last;
    logic [DIG_IDX_BITS-1:0] n_top;
    logic [DIG_IDX_BITS-1:0] n_idx;
    logic                    w_accept;

    // Most significant nonzero digit; zero gives digit position zero.
    always_comb begin
        n_top = '0;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (i_result.bcd[4*d +: 4] != 4'd0) begin
                n_top = DIG_IDX_BITS'(d);
            end
        end
    end

    assign w_accept = r_valid && i_ready;
    assign n_idx    = r_idx - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.done) begin
            r_valid <= 1'b1;
        end else if (w_accept && r_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.done) begin
            r_bcd  <= i_result.bcd;
            r_idx  <= n_top;
            r_char <= ASCII_ZERO + {2'b00, i_result.bcd[4*n_top +: 4]};
            r_last <= (n_top == '0);
        end else if (w_accept && !r_last) begin
            r_idx  <= n_idx;
            r_char <= ASCII_ZERO + {2'b00, r_bcd[4*n_idx +: 4]};
            r_last <= (n_idx == '0);
        end
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;
    assign o_done       = w_accept && r_last;

endmodule

// ----- hw/rtl/binary_to_decimal_ascii_msd_first_unit.sv -----
// Binary to decimal ASCII converter, most significant digit first.
// The first digit beat is offered after the 32 shift-add-3 steps of the conversion
// unit and one load into the output stage; each item gives n = 1 to 10 digit beats.
// One item at a time; input ready only while idle. Reset: i_rst_n, synchronous,
// active low, clears the sequencer and all valid flags. Depends on b2d_pkg.
module binary_to_decimal_ascii_msd_first_unit import b2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [INPUT_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [5:0]            o_digit_char,
    output logic                  o_last_digit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]   r_state;
    logic         w_start;
    logic         w_emit_done;
    t_conv_result w_result;

    assign o_ready = (r_state == ST_IDLE);
    assign w_start = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (w_result.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    b2d_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (i_value),
        .o_result (w_result)
    );

    b2d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (w_result),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .o_done       (w_emit_done)
    );

`ifndef ASSERT_OFF
    // The conversion only finishes while the sequencer waits for it.
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.done |-> (r_state == ST_CONV))
        else $error("conversion finished outside the conversion phase");

    // Digit beats are offered only in the emit phase.
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_EMIT))
        else $error("digit beat offered outside the emit phase");

    // Every offered character is a decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57))
        else $error("digit character out of range");

    // After the last digit is taken the block returns to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_digit) |=> o_ready)
        else $error("block not idle after the last digit beat");
`endif

endmodule

// ----- tb/b2d_digit_checker.sv -----
// Checker for the binary to decimal ASCII converter: watches both channels,
// predicts the digit beats of each accepted value and compares them in order.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_digit_checker import b2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [INPUT_BITS-1:0] i_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [5:0]            i_digit_char,
    input  logic                  i_last_digit,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;
    localparam longint unsigned DISPLAY_WRAP = 64'd10000000000;

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last_digit;
    } t_digit_beat;

    t_digit_beat expected_digits[$];
    int          error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = expected_digits.size();

    // Queues the characters of one value, most significant digit first.
    function automatic void queue_decimal_digits(input logic [INPUT_BITS-1:0] value);
        longint unsigned rest;
        logic [3:0]      digits [BCD_DIGITS];
        int              count;
        t_digit_beat     beat;
        rest  = longint'(value) % DISPLAY_WRAP;
        count = 0;
        do begin
            digits[count] = 4'(rest % 10);
            rest          = rest / 10;
            count++;
        end while (rest != 0 && count < BCD_DIGITS);
        for (int k = 0; k < count; k++) begin
            beat.digit_char = ASCII_ZERO + 6'(digits[count - 1 - k]);
            beat.last_digit = (k == count - 1);
            expected_digits.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_beat want;
        if (i_rst_n) begin
            // An output beat always belongs to an earlier value, so compare first.
            if (i_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: unexpected digit beat char=%0d last=%0b",
                                 $realtime, i_digit_char, i_last_digit);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (want.digit_char !== i_digit_char) begin
                        if (error_count < MAX_REPORTS)
                            $display("%0t: digit_char expected %0d, got %0d",
                                     $realtime, want.digit_char, i_digit_char);
                        error_count++;
                    end
                    if (want.last_digit !== i_last_digit) begin
                        if (error_count < MAX_REPORTS)
                            $display("%0t: last_digit expected %0b, got %0b",
                                     $realtime, want.last_digit, i_last_digit);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                queue_decimal_digits(i_value);
        end
    end

endmodule

// ----- tb/tb_binary_to_decimal_ascii_msd_first_unit.sv -----
// Top of the converter testbench: clock, reset, value stimulus, output stalls,
// watchdog and verdict. Uses b2d_pkg and the b2d_digit_checker module.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_msd_first_unit import b2d_pkg::*;;

    localparam int RANDOM_VALUES  = 380;
    localparam int IDLE_PERCENT   = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  i_ready = 1'b0;
    logic [INPUT_BITS-1:0] i_value = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [5:0]            o_digit_char;
    logic                  o_last_digit;

    logic steady_flow = 1'b0;
    int   quiet_cycles = 0;
    int   error_count;
    int   pending_count;

    binary_to_decimal_ascii_msd_first_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    b2d_digit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_digit_char (o_digit_char),
        .i_last_digit (o_last_digit),
        .o_errors     (error_count),
        .o_pending    (pending_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_binary_to_decimal_ascii_msd_first_unit: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Usually picks a digit count first so that short and long numbers are about equally common.
    function automatic logic [INPUT_BITS-1:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        int              width;
        if ($urandom_range(99) < 15)
            return INPUT_BITS'($urandom);
        width = $urandom_range(10, 1);
        lo = 1;
        for (int k = 1; k < width; k++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (width == 1)
            lo = 0;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        return INPUT_BITS'($urandom_range(int'(hi), int'(lo)));
    endfunction

    // Offers one value beat and returns at the edge where it is taken.
    task automatic send_value(input logic [INPUT_BITS-1:0] value);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
            gap = $urandom_range(45, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        logic [INPUT_BITS-1:0] corner_values[$];
        corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                          32'd12345, 32'd999999, 32'd1000000, 32'd99999999,
                          32'd999999999, 32'd1000000000, 32'd1410065407,
                          32'd1410065408, 32'd1500000000, 32'd2147483647,
                          32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_values[k])
            send_value(corner_values[k]);
        for (int n = 0; n < RANDOM_VALUES; n++) begin
            // A long stretch runs with both sides at full rate.
            steady_flow <= (n >= 120 && n < 200);
            send_value(pick_value());
        end
        i_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("tb_binary_to_decimal_ascii_msd_first_unit: done, clean");
        else
            $display("tb_binary_to_decimal_ascii_msd_first_unit: done, errors");
        $finish;
    end

endmodule

// ----- binary_to_decimal_ascii_msd_first_unit.f -----
hw/rtl/b2d_pkg.sv
hw/rtl/b2d_dabble.sv
hw/rtl/b2d_emit.sv
hw/rtl/binary_to_decimal_ascii_msd_first_unit.sv
tb/b2d_digit_checker.sv
tb/tb_binary_to_decimal_ascii_msd_first_unit.sv
